>>> sv/cialu_pkg.sv
package cialu_pkg;

   localparam int unsigned MaxExponentDefault = 15;
   localparam int unsigned PartWidth = 16;
   localparam int unsigned ResWidth = 32;
   localparam int unsigned MagWidth = 24;
   localparam int unsigned ExpWidth = 4;
   localparam int unsigned CmdWidth = 3;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_POW = 3'd4,
      CMD_MAG = 3'd5,
      CMD_RSV6 = 3'd6,
      CMD_RSV7 = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [CmdWidth-1:0]         cmd;
      logic signed [PartWidth-1:0] a_re;
      logic signed [PartWidth-1:0] a_im;
      logic signed [PartWidth-1:0] b_re;
      logic signed [PartWidth-1:0] b_im;
      logic [ExpWidth-1:0]         exponent;
   } req_type;

   typedef struct packed {
      logic signed [ResWidth-1:0] res_re;
      logic signed [ResWidth-1:0] res_im;
      logic [MagWidth-1:0]        magnitude;
      logic                       div_by_zero;
   } rsp_type;

   // control from sequencer to shared multiplier
   typedef struct packed {
      logic                valid;
      logic [ResWidth-1:0] x;
      logic [ResWidth-1:0] y;
   } mul_req_type;

endpackage

>>> sv/complex_integer_alu.sv
// Complex integer ALU.
// Drive req with a request and raise start while busy is low; the request
// is taken at that edge and busy stays high until the result has gone.
// Commands: add, subtract, multiply, divide, power, magnitude.
// One result appears on rsp for one cycle with rsp_valid high; the
// receiver cannot stall, so it must sample rsp at that edge.
// Work done between the accepting edge and the result edge:
//   add, subtract, unknown command, power with exponent 0: result formed at the accepting edge;
//   multiply: four products on the shared
//   32x32 multiplier; power: four products per exponent step;
//   divide: eight products, then two 34-step restoring divisions
//   through one shared divider; divide by zero: the eight products only;
//   magnitude: two products, then 24 bit-pair square root steps.
// One request is in flight at a time; the next one can be taken after
// the result has gone.
// Reset clears the sequencer; busy is low and no result is pending.
// Exponents above MAX_EXPONENT are saturated.
module complex_integer_alu #(
   parameter int unsigned MAX_EXPONENT = cialu_pkg::MaxExponentDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cialu_pkg::req_type req,
   output logic               rsp_valid,
   output cialu_pkg::rsp_type rsp
);
   import cialu_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_MUL  = 8'b00000010,
      ST_MWT  = 8'b00000100,
      ST_DIV  = 8'b00001000,
      ST_DWT  = 8'b00010000,
      ST_SQRT = 8'b00100000,
      ST_DONE = 8'b01000000,
      ST_ACC  = 8'b10000000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff;
   logic [31:0] xr_ff, xi_ff, yr_ff, yi_ff;
   logic [1:0]  pidx_ff;
   logic [3:0]  cnt_ff;
   logic        divsel_ff;
   logic [33:0] num_re_ff, num_im_ff;
   logic [32:0] den_ff;
   logic [33:0] q_re_ff;
   logic        neg_re_ff, neg_im_ff;
   logic [47:0] sq_n_ff;
   logic [49:0] sq_r_ff;
   logic [23:0] sq_root_ff;
   logic [4:0]  sq_cnt_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_start;
   logic [31:0] prod;
   mul_req_type mreq;
   logic        dstart, ddone;
   logic [33:0] dnum, dquot;
   logic [3:0]  exp_sat;
   logic [31:0] p0_ff, p1_ff, p2_ff;
   logic [49:0] sq_t;
   logic        more_prod, den_zero, last_pow;

   assign exp_sat = (32'(req.exponent) > MAX_EXPONENT) ? 4'(MAX_EXPONENT)
                                                       : req.exponent;

   always_comb begin
      mreq.valid = (state_ff == ST_MUL);
      unique case (pidx_ff)
         2'd0: begin mreq.x = xr_ff; mreq.y = yr_ff; end
         2'd1: begin mreq.x = xi_ff; mreq.y = yi_ff; end
         2'd2: begin mreq.x = xr_ff; mreq.y = yi_ff; end
         default: begin mreq.x = xi_ff; mreq.y = yr_ff; end
      endcase
   end

   cialu_mul u_mul (.clock(clock), .mul_req(mreq), .mul_prod_ff(prod));

   assign dstart = (state_ff == ST_DIV);
   assign dnum   = divsel_ff ? (num_im_ff[33] ? -num_im_ff : num_im_ff)
                             : (num_re_ff[33] ? -num_re_ff : num_re_ff);

   cialu_divider u_div (
      .clock(clock), .reset(reset), .div_start(dstart), .div_num(dnum),
      .div_den(den_ff), .div_done(ddone), .div_quot_ff(dquot)
   );

   assign sq_t = {sq_r_ff[47:0], sq_n_ff[47:46]} - {24'd0, sq_root_ff, 2'b01};

   assign more_prod = (pidx_ff != 2'd3) && !(cmd_ff == CMD_MAG && pidx_ff == 2'd1);
   assign den_zero  = (p0_ff == 32'd0) && (p1_ff == 32'd0);
   assign last_pow  = (cnt_ff == 4'd1);

   always_comb begin
      rsp_start = '0;
      unique case (cmd_type'(req.cmd)) inside
         CMD_ADD: begin
            rsp_start.res_re = 32'(req.a_re) + 32'(req.b_re);
            rsp_start.res_im = 32'(req.a_im) + 32'(req.b_im);
         end
         CMD_SUB: begin
            rsp_start.res_re = 32'(req.a_re) - 32'(req.b_re);
            rsp_start.res_im = 32'(req.a_im) - 32'(req.b_im);
         end
         CMD_POW: rsp_start.res_re = 32'sd1;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            unique case (cmd_type'(req.cmd)) inside
               CMD_MUL, CMD_DIV, CMD_MAG: state_in = ST_MUL;
               CMD_POW: state_in = (exp_sat == 4'd0) ? ST_DONE : ST_MUL;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL:  state_in = ST_MWT;
         ST_MWT:  state_in = ST_ACC;
         ST_ACC: begin
            if (more_prod) begin
               state_in = ST_MUL;
            end else if (cmd_ff == CMD_MAG) begin
               state_in = ST_SQRT;
            end else if (cmd_ff == CMD_POW) begin
               state_in = last_pow ? ST_DONE : ST_MUL;
            end else if (cmd_ff == CMD_MUL) begin
               state_in = ST_DONE;
            end else if (!divsel_ff) begin
               state_in = ST_MUL;
            end else begin
               state_in = den_zero ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV:  state_in = ST_DWT;
         ST_DWT:  if (ddone) state_in = divsel_ff ? ST_DONE : ST_DIV;
         ST_SQRT: state_in = (sq_cnt_ff == 5'd0) ? ST_DONE : ST_SQRT;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
         unique case (state_ff)
            ST_IDLE: if (start) begin
               cmd_ff     <= cmd_type'(req.cmd);
               pidx_ff    <= 2'd0;
               rsp_ff     <= rsp_start;
               cnt_ff     <= exp_sat;
               divsel_ff  <= 1'b0;
               sq_cnt_ff  <= 5'd23;
               sq_root_ff <= '0;
               sq_r_ff    <= '0;
               unique case (cmd_type'(req.cmd)) inside
                  CMD_POW: begin
                     xr_ff <= 32'd1; xi_ff <= 32'd0;
                     yr_ff <= 32'(req.a_re); yi_ff <= 32'(req.a_im);
                  end
                  CMD_MAG: begin
                     xr_ff <= 32'(req.a_re); xi_ff <= 32'(req.a_im);
                     yr_ff <= 32'(req.a_re); yi_ff <= 32'(req.a_im);
                  end
                  default: begin
                     xr_ff <= 32'(req.a_re); xi_ff <= 32'(req.a_im);
                     yr_ff <= 32'(req.b_re); yi_ff <= 32'(req.b_im);
                  end
               endcase
            end
            ST_ACC: begin
               unique case (pidx_ff)
                  2'd0: p0_ff <= prod;
                  2'd1: p1_ff <= prod;
                  2'd2: p2_ff <= prod;
                  default: ;
               endcase
               if (more_prod) begin
                  pidx_ff <= pidx_ff + 2'd1;
               end else if (cmd_ff == CMD_MAG) begin
                  sq_n_ff <= {p0_ff + prod, 16'd0};
               end else if (cmd_ff == CMD_POW) begin
                  xr_ff   <= p0_ff - p1_ff;
                  xi_ff   <= p2_ff + prod;
                  cnt_ff  <= cnt_ff - 4'd1;
                  pidx_ff <= 2'd0;
                  if (last_pow) begin
                     rsp_ff.res_re <= p0_ff - p1_ff;
                     rsp_ff.res_im <= p2_ff + prod;
                  end
               end else if (cmd_ff == CMD_MUL) begin
                  rsp_ff.res_re <= p0_ff - p1_ff;
                  rsp_ff.res_im <= p2_ff + prod;
               end else if (!divsel_ff) begin
                  // first pass: a*conj(b) parts; second: |b|^2
                  num_re_ff <= {{2{p0_ff[31]}}, p0_ff} + {{2{p1_ff[31]}}, p1_ff};
                  num_im_ff <= {{2{prod[31]}}, prod} - {{2{p2_ff[31]}}, p2_ff};
                  xr_ff <= yr_ff; xi_ff <= yi_ff;
                  divsel_ff <= 1'b1;
                  pidx_ff <= 2'd0;
               end else begin
                  den_ff <= {1'b0, p0_ff} + {1'b0, p1_ff};
                  divsel_ff <= 1'b0;
                  if (den_zero) begin
                     rsp_ff.div_by_zero <= 1'b1;
                  end else begin
                     neg_re_ff <= num_re_ff[33];
                     neg_im_ff <= num_im_ff[33];
                  end
               end
            end
            ST_DWT: if (ddone) begin
               if (!divsel_ff) begin
                  q_re_ff   <= neg_re_ff ? -dquot : dquot;
                  divsel_ff <= 1'b1;
               end else begin
                  rsp_ff.res_re <= q_re_ff[31:0];
                  rsp_ff.res_im <= neg_im_ff ? -dquot[31:0] : dquot[31:0];
               end
            end
            ST_SQRT: begin
               sq_n_ff <= {sq_n_ff[45:0], 2'b00};
               if (!sq_t[49]) begin
                  sq_r_ff    <= sq_t;
                  sq_root_ff <= {sq_root_ff[22:0], 1'b1};
               end else begin
                  sq_r_ff    <= {sq_r_ff[47:0], sq_n_ff[47:46]};
                  sq_root_ff <= {sq_root_ff[22:0], 1'b0};
               end
               sq_cnt_ff <= sq_cnt_ff - 5'd1;
               if (sq_cnt_ff == 5'd0) begin
                  rsp_ff.magnitude <= !sq_t[49] ? {sq_root_ff[22:0], 1'b1}
                                                : {sq_root_ff[22:0], 1'b0};
               end
            end
            default: ;
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy did not rise");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_dz_div_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.div_by_zero) |-> (rsp.res_re == 0 && rsp.res_im == 0))
      else $error("div_by_zero with nonzero result");

endmodule

>>> sv/cialu_mul.sv
module cialu_mul (
   input  logic                     clock,
   input  cialu_pkg::mul_req_type   mul_req,
   output logic [31:0]              mul_prod_ff
);
   import cialu_pkg::*;

   always_ff @(posedge clock) begin
      if (mul_req.valid) begin
         mul_prod_ff <= mul_req.x * mul_req.y;
      end
   end

endmodule

>>> sv/cialu_divider.sv
module cialu_divider (
   input  logic         clock,
   input  logic         reset,
   input  logic         div_start,
   input  logic [33:0]  div_num,
   input  logic [32:0]  div_den,
   output logic         div_done,
   output logic [33:0]  div_quot_ff
);
   import cialu_pkg::*;

   logic [33:0] rem_ff, rem_in;
   logic [33:0] quot_in;
   logic [32:0] den_ff;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [34:0] trial;

   assign trial = {rem_ff[33:0], div_quot_ff[33]} - {2'd0, den_ff};
   assign div_done = busy_ff && (count_ff == 6'd0);

   always_comb begin
      rem_in   = rem_ff;
      quot_in  = div_quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (div_start) begin
         rem_in   = '0;
         quot_in  = div_num;
         count_in = 6'd34;
         busy_in  = 1'b1;
      end else if (busy_ff && count_ff != 6'd0) begin
         if (!trial[34]) begin
            rem_in  = trial[33:0];
            quot_in = {div_quot_ff[32:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[32:0], div_quot_ff[33]};
            quot_in = {div_quot_ff[32:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
      end else if (div_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff      <= rem_in;
      div_quot_ff <= quot_in;
      if (div_start) den_ff <= div_den;
   end

endmodule

>>> test/testbench.sv
module testbench;
   import cialu_pkg::*;

   class alu_scoreboard;
      rsp_type pending[$];
      int errors;
      int shown;

      function automatic logic [31:0] wrap_div(longint num, longint den);
         return 32'(num / den);
      endfunction

      function automatic logic [23:0] floor_sqrt(longint unsigned n);
         longint unsigned root;
         longint unsigned bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n = n - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root[23:0];
      endfunction

      function automatic rsp_type compute(req_type r);
         rsp_type o;
         longint ar, ai, br, bi, den;
         logic [31:0] pr, pi, zr, zi, nr;
         int e;
         ar = r.a_re;
         ai = r.a_im;
         br = r.b_re;
         bi = r.b_im;
         o = '0;
         case (cmd_type'(r.cmd))
            CMD_ADD: begin
               o.res_re = 32'(ar + br);
               o.res_im = 32'(ai + bi);
            end
            CMD_SUB: begin
               o.res_re = 32'(ar - br);
               o.res_im = 32'(ai - bi);
            end
            CMD_MUL: begin
               o.res_re = 32'(ar * br - ai * bi);
               o.res_im = 32'(ar * bi + ai * br);
            end
            CMD_DIV: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  o.div_by_zero = 1'b1;
               end else begin
                  o.res_re = wrap_div(ar * br + ai * bi, den);
                  o.res_im = wrap_div(ai * br - ar * bi, den);
               end
            end
            CMD_POW: begin
               e = r.exponent;
               if (e > MaxExponentDefault) e = MaxExponentDefault;
               zr = 32'(ar);
               zi = 32'(ai);
               pr = 32'd1;
               pi = 32'd0;
               for (int k = 0; k < e; k++) begin
                  nr = pr * zr - pi * zi;
                  pi = pr * zi + pi * zr;
                  pr = nr;
               end
               o.res_re = pr;
               o.res_im = pi;
            end
            CMD_MAG: o.magnitude = floor_sqrt(longint'(ar * ar + ai * ai) << 16);
            default: o = '0;
         endcase
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(compute(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (shown++ < 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (shown++ < 10) begin
               $display("mismatch: expected re %0d im %0d mag %0d dz %0d",
                        want.res_re, want.res_im, want.magnitude, want.div_by_zero);
               $display("          got      re %0d im %0d mag %0d dz %0d",
                        got.res_re, got.res_im, got.magnitude, got.div_by_zero);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req;
   logic rsp_valid;
   rsp_type rsp;
   alu_scoreboard board;

   complex_integer_alu dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp);
   end

   function automatic logic [15:0] pick_part();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 6)) - 3);
         4: return 16'(int'($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic wait_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      repeat (n) @(posedge clock);
   endtask

   task automatic send(req_type r);
      while (busy) @(posedge clock);
      start <= 1'b1;
      req <= r;
      @(posedge clock);
      board.note_request(r);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_fields(cmd_type c, int ar, int ai, int br, int bi, int e);
      req_type r;
      r.cmd = c;
      r.a_re = 16'(ar);
      r.a_im = 16'(ai);
      r.b_re = 16'(br);
      r.b_im = 16'(bi);
      r.exponent = 4'(e);
      send(r);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (board.pending.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   initial begin
      req_type r;
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_fields(CMD_ADD, 32767, 32767, 32767, 32767, 0);
      send_fields(CMD_ADD, -32768, -32768, -32768, -32768, 0);
      send_fields(CMD_SUB, -32768, 32767, 32767, -32768, 0);
      send_fields(CMD_MUL, -32768, -32768, -32768, -32768, 0);
      send_fields(CMD_MUL, 32767, -32768, -32768, 32767, 0);
      send_fields(CMD_DIV, 100, -7, 0, 0, 0);
      send_fields(CMD_DIV, -7, 5, 2, 0, 0);
      send_fields(CMD_DIV, -32768, -32768, 1, 0, 0);
      send_fields(CMD_DIV, 32767, -32768, -32768, -32768, 0);
      send_fields(CMD_POW, 3, -2, 0, 0, 0);
      send_fields(CMD_POW, 0, 0, 0, 0, 0);
      send_fields(CMD_POW, -32768, 32767, 0, 0, 15);
      send_fields(CMD_POW, 1, 1, 0, 0, 8);
      send_fields(CMD_MAG, 0, 0, 0, 0, 0);
      send_fields(CMD_MAG, -32768, -32768, 0, 0, 0);
      send_fields(CMD_MAG, 3, 4, 0, 0, 0);
      send_fields(CMD_MAG, 1, 1, 0, 0, 0);
      send_fields(CMD_RSV6, 5, 5, 5, 5, 5);
      send_fields(CMD_RSV7, -1, -1, -1, -1, 15);
      drain();

      for (int i = 0; i < 750; i++) begin
         r.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
         r.a_re = pick_part();
         r.a_im = pick_part();
         r.b_re = pick_part();
         r.b_im = pick_part();
         r.exponent = 4'($urandom);
         if (r.cmd == CMD_DIV && $urandom_range(0, 7) == 0) begin
            r.b_re = '0;
            r.b_im = '0;
         end
         if ($urandom_range(0, 3) != 0) wait_gap();
         send(r);
         if (i == 375) drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
sv/cialu_pkg.sv
sv/cialu_mul.sv
sv/cialu_divider.sv
sv/complex_integer_alu.sv
test/testbench.sv
